### rtl/core/sram_pkg.sv
package sram_pkg;

    // Command codes carried by the kind field.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // Masks and reset values of the serial engine.
    localparam logic [7:0]  WRITE_FLAG       = 8'h80;
    localparam logic [6:0]  ADDR_MASK        = 7'h7F;
    localparam logic [15:0] HALF_PERIOD_INIT = 16'h0800;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    // Transaction phases, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ADDR  = 5'b00010,
        PH_WAIT  = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CLOSE = 5'b10000
    } phase_t;

    // One input item.
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] reg_address;
        logic       is_write;
        logic [7:0] write_byte;
        logic       last_byte;
        logic       miso;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       cs_n;
        logic       sck;
        logic       mosi;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       ready_res;
        logic       done_res;
    } result_t;

endpackage

### rtl/core/sram_core.sv
module sram_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_write,
    input  logic [15:0]      cfg_half_period,
    input  logic             item_accept,
    input  sram_pkg::item_t  item,
    output sram_pkg::result_t result
);
    import sram_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [15:0] divider_reg, divider_next;
    logic        sck_reg, sck_next;
    logic        select_n_reg, select_n_next;
    logic        write_mode_reg, write_mode_next;
    logic        final_flag_reg, final_flag_next;
    logic [15:0] half_period_reg;

    logic [15:0] hp;
    logic [16:0] div_inc;
    logic        tick;
    logic        reading;
    logic        rvalid;
    logic [7:0]  rbyte;
    logic        done;

    // Divider: a zero half period behaves as one.
    assign hp      = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign div_inc = {1'b0, divider_reg} + 17'd1;
    assign tick    = (div_inc >= {1'b0, hp});
    assign reading = (phase_reg == PH_DATA) && !write_mode_reg;

    // Next state of the serial engine for one item.
    always_comb begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        divider_next    = divider_reg;
        sck_next        = sck_reg;
        select_n_next   = select_n_reg;
        write_mode_next = write_mode_reg;
        final_flag_next = final_flag_reg;
        rvalid          = 1'b0;
        rbyte           = 8'd0;
        done            = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (item.kind == KIND_START) begin
                    select_n_next   = 1'b0;
                    write_mode_next = item.is_write;
                    shift_next      = {1'b0, item.reg_address & ADDR_MASK}
                                      | (item.is_write ? WRITE_FLAG : 8'd0);
                    bit_count_next  = 4'd0;
                    divider_next    = 16'd0;
                    sck_next        = 1'b0;
                    final_flag_next = 1'b0;
                    phase_next      = PH_ADDR;
                end
            end
            PH_WAIT: begin
                if (item.kind == KIND_DATA) begin
                    shift_next      = write_mode_reg ? item.write_byte : 8'd0;
                    final_flag_next = item.last_byte;
                    bit_count_next  = 4'd0;
                    divider_next    = 16'd0;
                    sck_next        = 1'b0;
                    phase_next      = PH_DATA;
                end
            end
            PH_ADDR, PH_DATA: begin
                divider_next = tick ? 16'd0 : div_inc[15:0];
                if (tick) begin
                    if (!sck_reg) begin
                        // Rising edge: a read samples miso here.
                        sck_next = 1'b1;
                        if (reading) begin
                            shift_next = {shift_reg[6:0], item.miso};
                        end
                    end else begin
                        // Falling edge: the next bit goes out.
                        sck_next = 1'b0;
                        if (!reading) begin
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                        bit_count_next = bit_count_reg + 4'd1;
                        if (bit_count_next >= BITS_PER_BYTE) begin
                            bit_count_next = 4'd0;
                            if (phase_reg == PH_ADDR) begin
                                phase_next = PH_WAIT;
                            end else begin
                                if (reading) begin
                                    rvalid = 1'b1;
                                    rbyte  = shift_reg;
                                end
                                phase_next = final_flag_reg ? PH_CLOSE : PH_WAIT;
                            end
                        end
                    end
                end
            end
            PH_CLOSE: begin
                divider_next = tick ? 16'd0 : div_inc[15:0];
                if (tick) begin
                    select_n_next   = 1'b1;
                    done            = 1'b1;
                    write_mode_next = 1'b0;
                    final_flag_next = 1'b0;
                    shift_next      = 8'd0;
                    phase_next      = PH_IDLE;
                end
            end
            default: begin
                phase_next    = PH_IDLE;
                select_n_next = 1'b1;
                sck_next      = 1'b0;
            end
        endcase
    end

    // Pin levels and status as they stand after this item.
    always_comb begin
        result.cs_n       = select_n_next;
        result.sck        = sck_next;
        result.mosi       = ((phase_next == PH_ADDR)
                            || ((phase_next == PH_DATA) && write_mode_next))
                            ? shift_next[7] : 1'b0;
        result.read_byte  = rbyte;
        result.read_valid = rvalid;
        result.ready_res  = (phase_next == PH_IDLE) || (phase_next == PH_WAIT);
        result.done_res   = done;
    end

    // State advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            shift_reg       <= 8'd0;
            bit_count_reg   <= 4'd0;
            divider_reg     <= 16'd0;
            sck_reg         <= 1'b0;
            select_n_reg    <= 1'b1;
            write_mode_reg  <= 1'b0;
            final_flag_reg  <= 1'b0;
            half_period_reg <= HALF_PERIOD_INIT;
        end else begin
            if (item_accept) begin
                phase_reg      <= phase_next;
                shift_reg      <= shift_next;
                bit_count_reg  <= bit_count_next;
                divider_reg    <= divider_next;
                sck_reg        <= sck_next;
                select_n_reg   <= select_n_next;
                write_mode_reg <= write_mode_next;
                final_flag_reg <= final_flag_next;
            end
            if (cfg_write) begin
                half_period_reg <= cfg_half_period;
            end
        end
    end

`ifndef ASSERT_OFF
    // Chip select is high exactly when no transaction is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) == select_n_reg)
        else $error("chip select does not match the idle phase");

    // SCK is high only while a byte is shifting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sck_reg |-> (phase_reg == PH_ADDR || phase_reg == PH_DATA))
        else $error("sck high outside a shifting phase");

    // The bit counter wraps before it reaches a full byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg < BITS_PER_BYTE)
        else $error("bit counter out of range");
`endif

endmodule

### rtl/core/sram_out_buf.sv
module sram_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sram_pkg::result_t push_data,
    output logic              not_full,
    output logic              out_valid,
    input  logic              out_ready,
    output sram_pkg::result_t out_data
);
    import sram_pkg::*;

    result_t    head_reg, tail_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);
    assign out_data  = head_reg;

    // Occupancy of the two-entry result queue.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload moves toward the head as items leave.
    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                head_reg <= push_data;
            end else begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_reg <= push_data;
            end else begin
                tail_reg <= push_data;
            end
        end else if (pop) begin
            head_reg <= tail_reg;
        end
    end

`ifndef ASSERT_OFF
    // The queue never holds more than two items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue overflow");

    // An item pushed into an empty queue shows up at the head next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && count_reg == 2'd0) |=> (out_valid && out_data == $past(push_data)))
        else $error("pushed item not at head");

    // A full queue that is not drained keeps its head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !pop) |=> $stable(head_reg))
        else $error("head changed in a stalled full queue");
`endif

endmodule

### rtl/core/spi_register_access_master.sv
// SPI mode-0 register access master, stepped once per input item.
// Input channel (s_valid/s_ready): each item is one clock step of the
// serial engine and carries a command (kind), its operands and the miso
// level. Result channel (m_valid/m_ready): one item per input item with the
// pin levels cs_n, sck, mosi after that step, plus read_byte/read_valid,
// ready_res and done_res.
// Configuration channel (cfg_valid/cfg_ready): writes the SCK half period
// in steps; cfg_ready is always high. Writes are to be made while idle;
// the block does not enforce it. A result is queued when its item is
// accepted and reaches the m_ ports once earlier results have left. The
// engine takes one item per cycle while s_ready is high, a rate set by the
// single next-state pass between its state registers. A two-entry result
// queue lets s_ready stay high while one result waits; when the receiver
// stalls with two results queued, s_ready drops until one leaves. Reset
// closes any transaction: cs_n high, sck low, half period 2048, empty queue.
module spi_register_access_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_half_period,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [6:0]  s_reg_address,
    input  logic        s_is_write,
    input  logic [7:0]  s_write_byte,
    input  logic        s_last_byte,
    input  logic        s_miso,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cs_n,
    output logic        m_sck,
    output logic        m_mosi,
    output logic [7:0]  m_read_byte,
    output logic        m_read_valid,
    output logic        m_ready_res,
    output logic        m_done_res
);
    import sram_pkg::*;

    item_t   item;
    result_t step_result;
    result_t out_data;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Gather the input fields into one item.
    always_comb begin
        item.kind        = s_kind;
        item.reg_address = s_reg_address;
        item.is_write    = s_is_write;
        item.write_byte  = s_write_byte;
        item.last_byte   = s_last_byte;
        item.miso        = s_miso;
    end

    sram_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_half_period (cfg_half_period),
        .item_accept     (accept),
        .item            (item),
        .result          (step_result)
    );

    sram_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (step_result),
        .not_full  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // Spread the queued result over the output ports.
    assign m_cs_n       = out_data.cs_n;
    assign m_sck        = out_data.sck;
    assign m_mosi       = out_data.mosi;
    assign m_read_byte  = out_data.read_byte;
    assign m_read_valid = out_data.read_valid;
    assign m_ready_res  = out_data.ready_res;
    assign m_done_res   = out_data.done_res;

endmodule

### dv/spi_pin_checker.sv
`timescale 1ns / 1ps

module spi_pin_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_half_period,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [6:0]  s_reg_address,
    input  logic        s_is_write,
    input  logic [7:0]  s_write_byte,
    input  logic        s_last_byte,
    input  logic        s_miso,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_cs_n,
    input  logic        m_sck,
    input  logic        m_mosi,
    input  logic [7:0]  m_read_byte,
    input  logic        m_read_valid,
    input  logic        m_ready_res,
    input  logic        m_done_res,
    output int          fail_count,
    output int          pending
);
    import sram_pkg::*;

    // Shadow copy of the serial engine and its divider register.
    phase_t      eng_phase;
    logic [7:0]  eng_shift;
    logic [3:0]  eng_bits;
    logic [15:0] eng_div;
    logic        eng_sck;
    logic        eng_sel_n;
    logic        eng_write;
    logic        eng_last;
    logic [15:0] half_period;

    // Pin states predicted for items whose result has not arrived yet.
    result_t expected_pins[$];

    // Counts one step of the SCK divider; a zero half period behaves as one.
    function automatic logic divider_tick();
        logic [16:0] nxt;
        logic [16:0] limit;
        nxt = {1'b0, eng_div} + 17'd1;
        limit = (half_period == '0) ? 17'd1 : {1'b0, half_period};
        if (nxt >= limit) begin
            eng_div = '0;
            return 1'b1;
        end
        eng_div = nxt[15:0];
        return 1'b0;
    endfunction

    // Advances the shadow engine by one item and returns the pins after it.
    task automatic advance_spi_engine(input item_t it, output result_t r);
        logic reading;
        r = '0;
        reading = 1'b0;
        case (eng_phase)
            PH_IDLE: begin
                if (it.kind == KIND_START) begin
                    eng_sel_n = 1'b0;
                    eng_write = it.is_write;
                    eng_shift = (it.is_write ? WRITE_FLAG : 8'h00) |
                                {1'b0, it.reg_address & ADDR_MASK};
                    eng_bits = '0;
                    eng_div = '0;
                    eng_sck = 1'b0;
                    eng_last = 1'b0;
                    eng_phase = PH_ADDR;
                end
            end
            PH_WAIT: begin
                if (it.kind == KIND_DATA) begin
                    eng_shift = eng_write ? it.write_byte : 8'h00;
                    eng_last = it.last_byte;
                    eng_bits = '0;
                    eng_div = '0;
                    eng_sck = 1'b0;
                    eng_phase = PH_DATA;
                end
            end
            PH_ADDR, PH_DATA: begin
                if (divider_tick()) begin
                    reading = (eng_phase == PH_DATA) && !eng_write;
                    if (!eng_sck) begin
                        // Rising edge: a read samples miso here.
                        eng_sck = 1'b1;
                        if (reading) eng_shift = {eng_shift[6:0], it.miso};
                    end else begin
                        // Falling edge: outgoing data moves to the next bit.
                        eng_sck = 1'b0;
                        if (!reading) eng_shift = {eng_shift[6:0], 1'b0};
                        eng_bits = eng_bits + 4'd1;
                        if (eng_bits >= BITS_PER_BYTE) begin
                            eng_bits = '0;
                            if (eng_phase == PH_ADDR) begin
                                eng_phase = PH_WAIT;
                            end else begin
                                if (reading) begin
                                    r.read_valid = 1'b1;
                                    r.read_byte = eng_shift;
                                end
                                eng_phase = eng_last ? PH_CLOSE : PH_WAIT;
                            end
                        end
                    end
                end
            end
            PH_CLOSE: begin
                if (divider_tick()) begin
                    eng_sel_n = 1'b1;
                    r.done_res = 1'b1;
                    eng_write = 1'b0;
                    eng_last = 1'b0;
                    eng_shift = '0;
                    eng_phase = PH_IDLE;
                end
            end
            default: begin
                eng_phase = PH_IDLE;
                eng_sel_n = 1'b1;
                eng_sck = 1'b0;
            end
        endcase
        r.cs_n = eng_sel_n;
        r.sck = eng_sck;
        r.mosi = (eng_phase == PH_ADDR || (eng_phase == PH_DATA && eng_write)) ?
                 eng_shift[7] : 1'b0;
        r.ready_res = (eng_phase == PH_IDLE || eng_phase == PH_WAIT);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Results are popped before new items are pushed, since a result
    // always belongs to an item accepted at an earlier edge.
    always @(posedge aclk) begin : watch
        item_t   it;
        result_t want;
        result_t got;
        if (!aresetn) begin
            eng_phase = PH_IDLE;
            eng_shift = '0;
            eng_bits = '0;
            eng_div = '0;
            eng_sck = 1'b0;
            eng_sel_n = 1'b1;
            eng_write = 1'b0;
            eng_last = 1'b0;
            half_period = HALF_PERIOD_INIT;
            fail_count = 0;
            expected_pins.delete();
        end else begin
            if (cfg_valid && cfg_ready) half_period = cfg_half_period;
            if (m_valid && m_ready) begin
                got = {m_cs_n, m_sck, m_mosi, m_read_byte, m_read_valid,
                       m_ready_res, m_done_res};
                if (expected_pins.size() == 0) begin
                    $display("%0t: result item with nothing expected, actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("cs_n", 8'(want.cs_n), 8'(got.cs_n));
                    check_field("sck", 8'(want.sck), 8'(got.sck));
                    check_field("mosi", 8'(want.mosi), 8'(got.mosi));
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
                    check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
                    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                end
            end
            if (s_valid && s_ready) begin
                it = {s_kind, s_reg_address, s_is_write, s_write_byte, s_last_byte, s_miso};
                advance_spi_engine(it, want);
                expected_pins.push_back(want);
            end
        end
        pending <= expected_pins.size();
    end

endmodule

### dv/spi_register_access_master_test.sv
`timescale 1ns / 1ps

module spi_register_access_master_test;
    import sram_pkg::*;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int EDGES_PER_BYTE = 2 * BITS_PER_BYTE;
    localparam int IDLE_PERCENT = 32;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT = 5000;
    localparam int SYNC_LIMIT = 4096;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_half_period = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [6:0]  s_reg_address = '0;
    logic        s_is_write = 1'b0;
    logic [7:0]  s_write_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        s_miso = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_cs_n;
    logic        m_sck;
    logic        m_mosi;
    logic [7:0]  m_read_byte;
    logic        m_read_valid;
    logic        m_ready_res;
    logic        m_done_res;

    // Stimulus bookkeeping.
    bit          calm = 1'b0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_reads = 0;
    int          n_closed = 0;
    int          stall_cycles = 0;
    logic        last_ready_res = 1'b0;
    logic [15:0] hp_now = HALF_PERIOD_INIT;
    int          fail_count;
    int          pending;

    always #4 aclk = ~aclk;

    spi_register_access_master u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_half_period (cfg_half_period),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_reg_address   (s_reg_address),
        .s_is_write      (s_is_write),
        .s_write_byte    (s_write_byte),
        .s_last_byte     (s_last_byte),
        .s_miso          (s_miso),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cs_n          (m_cs_n),
        .m_sck           (m_sck),
        .m_mosi          (m_mosi),
        .m_read_byte     (m_read_byte),
        .m_read_valid    (m_read_valid),
        .m_ready_res     (m_ready_res),
        .m_done_res      (m_done_res)
    );

    spi_pin_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_half_period (cfg_half_period),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_reg_address   (s_reg_address),
        .s_is_write      (s_is_write),
        .s_write_byte    (s_write_byte),
        .s_last_byte     (s_last_byte),
        .s_miso          (s_miso),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cs_n          (m_cs_n),
        .m_sck           (m_sck),
        .m_mosi          (m_mosi),
        .m_read_byte     (m_read_byte),
        .m_read_valid    (m_read_valid),
        .m_ready_res     (m_ready_res),
        .m_done_res      (m_done_res),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // The receiver stalls at random except during the calm stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Tally of returned items; the last ready_res tells where the engine stands.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            n_recv <= n_recv + 1;
            last_ready_res <= m_ready_res;
            if (m_read_valid) n_reads <= n_reads + 1;
            if (m_done_res) n_closed <= n_closed + 1;
        end
    end

    // Ends the run when no channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic item_t random_item();
        item_t it;
        it.kind = 2'($urandom_range(3));
        it.reg_address = 7'($urandom);
        it.is_write = 1'($urandom);
        it.write_byte = 8'($urandom);
        it.last_byte = 1'($urandom);
        it.miso = 1'($urandom);
        return it;
    endfunction

    function automatic int eff_half();
        return (hp_now == '0) ? 1 : int'(hp_now);
    endfunction

    task automatic send_item(input item_t it);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_reg_address <= it.reg_address;
        s_is_write <= it.is_write;
        s_write_byte <= it.write_byte;
        s_last_byte <= it.last_byte;
        s_miso <= it.miso;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
    endtask

    // Only called once every expected item has come back.
    task automatic write_half_period(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_half_period <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        hp_now = value;
    endtask

    // Steps while a byte shifts; any command here is ignored by the engine.
    // A miso mode of 0 or 1 holds the line at that level, otherwise it is random.
    task automatic send_fillers(input int count, input int miso_mode);
        item_t it;
        for (int k = 0; k < count; k++) begin
            it = random_item();
            if (miso_mode < 2) it.miso = miso_mode[0];
            send_item(it);
        end
    endtask

    // Items that the current phase does not take: anything but live_kind.
    task automatic send_noise(input int count, input logic [1:0] live_kind);
        item_t it;
        for (int k = 0; k < count; k++) begin
            it = random_item();
            while (it.kind == live_kind) it.kind = 2'($urandom_range(3));
            send_item(it);
        end
    endtask

    task automatic send_start(input logic [6:0] addr, input logic wr);
        item_t it;
        it = random_item();
        it.kind = KIND_START;
        it.reg_address = addr;
        it.is_write = wr;
        send_item(it);
    endtask

    task automatic send_data(input logic [7:0] value, input logic last);
        item_t it;
        it = random_item();
        it.kind = KIND_DATA;
        it.write_byte = value;
        it.last_byte = last;
        send_item(it);
    endtask

    // Steps one item at a time until the engine reports idle or between bytes.
    task automatic sync_to_ready();
        item_t it;
        int    tries;
        tries = 0;
        do begin
            it = random_item();
            it.kind = KIND_NONE;
            send_item(it);
            drain();
            tries++;
        end while (!last_ready_res && tries < SYNC_LIMIT);
    endtask

    // One whole burst from idle back to idle, timed from the half period.
    task automatic run_transaction(input logic [6:0] addr, input logic wr,
                                   input int n_bytes, input int miso_mode);
        int hp;
        hp = eff_half();
        send_noise($urandom_range(2), KIND_START);
        send_start(addr, wr);
        send_fillers(EDGES_PER_BYTE * hp, miso_mode);
        for (int b = 0; b < n_bytes; b++) begin
            send_noise($urandom_range(2), KIND_DATA);
            send_data(8'($urandom), b == n_bytes - 1);
            send_fillers(EDGES_PER_BYTE * hp, miso_mode);
        end
        send_fillers(hp, miso_mode);
    endtask

    initial begin : stimulus
        item_t it;
        int    base;
        int    roll;
        int    miso_mode;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Data and reserved commands while idle are both ignored.
        it = random_item();
        it.kind = KIND_DATA;
        send_item(it);
        it.kind = KIND_RESERVED;
        send_item(it);

        // Write burst opened at the reset divider, which then shrinks below the count.
        send_start(ADDR_MASK, 1'b1);
        send_fillers(10, 2);
        drain();
        write_half_period(16'd2);
        sync_to_ready();
        send_data(8'hFF, 1'b0);
        send_fillers(EDGES_PER_BYTE * 2, 2);
        it = random_item();
        it.kind = KIND_START;
        send_item(it);
        send_data(8'h00, 1'b1);
        send_fillers(EDGES_PER_BYTE * 2 + 2, 2);

        // A zero half period runs as one; reads of all ones and all zeros.
        drain();
        write_half_period(16'h0000);
        run_transaction(7'h00, 1'b0, 2, 1);
        run_transaction(7'h55, 1'b0, 1, 0);
        run_transaction(7'h2A, 1'b1, 3, 2);

        // Widest divider, cut short to one while the address shifts.
        drain();
        write_half_period(16'hFFFF);
        send_start(7'($urandom), 1'b0);
        send_fillers(5, 2);
        drain();
        write_half_period(16'd1);
        sync_to_ready();
        send_data(8'($urandom), 1'b1);
        send_fillers(EDGES_PER_BYTE + 1, 2);

        // Random bursts, with a new divider after each drained group.
        base = n_sent;
        for (int t = 0; n_sent - base < RANDOM_ITEMS; t++) begin
            if (t % 6 == 0) begin
                drain();
                write_half_period(16'($urandom_range(4)));
            end
            calm = (t >= 8 && t < 12);
            roll = $urandom_range(9);
            miso_mode = (roll == 0) ? 0 : ((roll == 1) ? 1 : 2);
            run_transaction(7'($urandom), 1'($urandom), $urandom_range(1, 4), miso_mode);
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        $display("Stepped the engine %0d times across half periods 0 to 65535,", n_sent);
        $display("returning %0d read bytes and closing %0d bursts.", n_reads, n_closed);
        if (pending != 0) $display("%0t: %0d expected items never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/sram_pkg.sv
rtl/core/sram_core.sv
rtl/core/sram_out_buf.sv
rtl/core/spi_register_access_master.sv
dv/spi_pin_checker.sv
dv/spi_register_access_master_test.sv
